FILE: design/fmpc_pkg.sv
// Package: rule entry and packet types, field codes and stream widths.
`default_nettype none
package fmpc_pkg;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 1;
  localparam int unsigned CntW     = 5;

  localparam logic OpWrite    = 1'b0;
  localparam logic OpClassify = 1'b1;

  localparam logic [1:0] KindTcp   = 2'd0;
  localparam logic [1:0] KindIp    = 2'd1;
  localparam logic [1:0] KindUdp   = 2'd1;
  localparam logic [1:0] KindIcmp  = 2'd2;
  localparam logic [1:0] KindOther = 2'd3;

  localparam logic CfgTcpCount = 1'b0;
  localparam logic CfgIpCount  = 1'b1;

  localparam logic TblTcp = 1'b0;
  localparam logic TblIp  = 1'b1;

  localparam logic [5:0] PrefixFull = 6'd32;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [5:0]  slen;
    logic [5:0]  dlen;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  any;
    logic [3:0]  alarm;
    logic [3:0]  proto;
  } rule_t;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        use_ports;
  } pkt_t;

endpackage
`default_nettype wire

FILE: design/fmpc_rule_mem.sv
// Rule table memory: both tables, one write port, one registered read port.
`default_nettype none
module fmpc_rule_mem
  import fmpc_pkg::*;
#(
  parameter int unsigned AW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire rule_t         wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output rule_t              rdata_o
);

  rule_t mem [2**AW];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/fmpc_rule_match.sv
// Rule compare: CIDR prefixes on both addresses plus exact or wildcard ports, unless the packet has none.
`default_nettype none
module fmpc_rule_match
  import fmpc_pkg::*;
(
  input  wire rule_t rule_i,
  input  wire pkt_t  pkt_i,
  output logic       hit_o
);

  function automatic logic prefix_covers(logic [31:0] addr, logic [31:0] net,
                                         logic [5:0] len);
    logic [31:0] mask;
    mask = ~(32'hFFFF_FFFF >> len);
    if (len == 6'd0) begin
      return 1'b1;
    end else if (len > PrefixFull) begin
      return 1'b0;
    end
    return ((addr ^ net) & mask) == 32'd0;
  endfunction

  logic sport_ok;
  logic dport_ok;
  logic addr_ok;

  always_comb begin
    sport_ok = !pkt_i.use_ports || rule_i.any[0] || (rule_i.sport == pkt_i.sport);
    dport_ok = !pkt_i.use_ports || rule_i.any[1] || (rule_i.dport == pkt_i.dport);
    addr_ok  = prefix_covers(pkt_i.saddr, rule_i.saddr, rule_i.slen) &&
               prefix_covers(pkt_i.daddr, rule_i.daddr, rule_i.dlen);
    hit_o    = sport_ok && dport_ok && addr_ok;
  end

endmodule
`default_nettype wire

FILE: design/first_match_packet_rule_classifier_unit.sv
// A write, an unsearched kind or an empty table gives its word in the cycle after accept.
// A classify scans one rule per cycle from the table memory; the first hit or the end of
// the active rules ends the scan, and the result is registered, then moved to the output register.
// One item is in work at a time; the next is taken once the output register can hold it.
// Reset clears the counts, the controller and the output valid; rule memory is undefined.
`default_nettype none
module first_match_packet_rule_classifier_unit
  import fmpc_pkg::*;
#(
  parameter int unsigned RULES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CntW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // rule_index, src_addr, src_prefix_len, dst_addr, dst_prefix_len,
  // src_port, dst_port, port_any, alarm_kind, proto_kind
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // op, kind
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // hit_index, hit_alarm, hit_proto
  output logic [OutDataW-1:0]      m_axis_tdata,
  // hit
  output logic [OutUserW-1:0]      m_axis_tuser
);

  localparam int unsigned IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned CW = $clog2(RULES + 1);
  localparam int unsigned AW = IW + 1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  logic        in_op;
  logic [1:0]  in_kind;
  logic [3:0]  in_idx;
  rule_t       in_rule;
  pkt_t        in_pkt;

  assign in_op   = s_axis_tuser[0];
  assign in_kind = s_axis_tuser[2:1];
  assign in_idx  = s_axis_tdata[3:0];

  always_comb begin
    in_rule.saddr = s_axis_tdata[35:4];
    in_rule.slen  = s_axis_tdata[41:36];
    in_rule.daddr = s_axis_tdata[73:42];
    in_rule.dlen  = s_axis_tdata[79:74];
    in_rule.sport = s_axis_tdata[95:80];
    in_rule.dport = s_axis_tdata[111:96];
    in_rule.any   = s_axis_tdata[113:112];
    in_rule.alarm = s_axis_tdata[117:114];
    in_rule.proto = s_axis_tdata[121:118];
    in_pkt.saddr     = in_rule.saddr;
    in_pkt.daddr     = in_rule.daddr;
    in_pkt.sport     = in_rule.sport;
    in_pkt.dport     = in_rule.dport;
    in_pkt.use_ports = (in_kind != KindIcmp);
  end

  state_e          state_q, state_d;
  logic [CntW-1:0] tcp_cnt_q, tcp_cnt_d;
  logic [CntW-1:0] ip_cnt_q, ip_cnt_d;
  pkt_t            pkt_q, pkt_d;
  logic            tbl_q, tbl_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]   cmp_idx_q, cmp_idx_d;
  logic            cmp_v_q, cmp_v_d;
  logic            res_hit_q, res_hit_d;
  logic [11:0]     res_data_q, res_data_d;
  logic            out_v_q, out_v_d;
  logic            out_hit_q, out_hit_d;
  logic [11:0]     out_data_q, out_data_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  rule_t           mem_rdata;
  logic            rule_hit;
  logic            accept;
  logic            out_free;
  logic [CntW-1:0] sel_cnt;
  logic            hit_now;
  logic            issue;

  fmpc_rule_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_rule),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fmpc_rule_match u_match (
    .rule_i (mem_rdata),
    .pkt_i  (pkt_q),
    .hit_o  (rule_hit)
  );

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sel_cnt       = (in_kind == KindTcp) ? tcp_cnt_q : ip_cnt_q;

  assign mem_we    = accept && (in_op == OpWrite) && (in_kind[1] == 1'b0) &&
                     (32'(in_idx) < RULES);
  assign mem_waddr = {in_kind[0], IW'(in_idx)};

  assign hit_now   = (state_q == StScan) && cmp_v_q && rule_hit;
  assign issue     = (state_q == StScan) && !hit_now && (rd_cnt_q < n_q);
  assign mem_re    = issue;
  assign mem_raddr = {tbl_q, rd_cnt_q[IW-1:0]};

  always_comb begin
    state_d    = state_q;
    tcp_cnt_d  = tcp_cnt_q;
    ip_cnt_d   = ip_cnt_q;
    pkt_d      = pkt_q;
    tbl_d      = tbl_q;
    n_d        = n_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_v_d    = 1'b0;
    res_hit_d  = res_hit_q;
    res_data_d = res_data_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_hit_d  = out_hit_q;
    out_data_d = out_data_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTcpCount: tcp_cnt_d = cfg_data_i;
        CfgIpCount:  ip_cnt_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          pkt_d    = in_pkt;
          tbl_d    = (in_kind == KindTcp) ? TblTcp : TblIp;
          n_d      = (32'(sel_cnt) > RULES) ? CW'(RULES) : CW'(sel_cnt);
          rd_cnt_d = '0;
          if ((in_op == OpClassify) && (in_kind != KindOther) && (sel_cnt != '0)) begin
            state_d = StScan;
          end else begin
            out_v_d    = 1'b1;
            out_hit_d  = 1'b0;
            out_data_d = '0;
          end
        end
      end
      StScan: begin
        if (hit_now) begin
          res_hit_d  = 1'b1;
          res_data_d = {mem_rdata.proto, mem_rdata.alarm, 4'(cmp_idx_q)};
          state_d    = StDone;
        end else if (issue) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_cnt_q;
          rd_cnt_d  = rd_cnt_q + CW'(1);
        end else begin
          res_hit_d  = 1'b0;
          res_data_d = '0;
          state_d    = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_hit_d  = res_hit_q;
          out_data_d = res_data_q;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      tcp_cnt_q  <= '0;
      ip_cnt_q   <= '0;
      pkt_q      <= '0;
      tbl_q      <= TblTcp;
      n_q        <= '0;
      rd_cnt_q   <= '0;
      cmp_idx_q  <= '0;
      cmp_v_q    <= 1'b0;
      res_hit_q  <= 1'b0;
      res_data_q <= '0;
      out_v_q    <= 1'b0;
      out_hit_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      tcp_cnt_q  <= tcp_cnt_d;
      ip_cnt_q   <= ip_cnt_d;
      pkt_q      <= pkt_d;
      tbl_q      <= tbl_d;
      n_q        <= n_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_idx_q  <= cmp_idx_d;
      cmp_v_q    <= cmp_v_d;
      res_hit_q  <= res_hit_d;
      res_data_q <= res_data_d;
      out_v_q    <= out_v_d;
      out_hit_q  <= out_hit_d;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

endmodule
`default_nettype wire

FILE: sim/first_match_packet_rule_classifier_unit_test.sv
// Testbench: classifier words against a first-match predictor under random stalls.
`timescale 1ns / 1ps
module first_match_packet_rule_classifier_unit_test
  import fmpc_pkg::*;
();

  localparam int RuleSlots = 16;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic       op;
    logic [1:0] kind;
    logic [3:0] idx;
    rule_t      body;
  } hdr_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
    logic [3:0] alarm;
    logic [3:0] proto;
  } verdict_t;

  typedef struct {
    bit         set_cnt;
    logic [4:0] tcp_cnt;
    logic [4:0] ip_cnt;
    hdr_t       h;
    bit         want_zero;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = CfgTcpCount;
  logic [CntW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  rule_t       tcp_tab [RuleSlots];
  rule_t       ip_tab [RuleSlots];
  logic [4:0]  tcp_n = '0;
  logic [4:0]  ip_n = '0;
  verdict_t    verdict_q [$];
  row_t        dir_rows [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  first_match_packet_rule_classifier_unit #(.RULES(RuleSlots)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] prefix_mask(logic [5:0] len);
    if (len == 6'd0 || len > PrefixFull) begin
      return 32'h0;
    end
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic bit addr_in_prefix(logic [31:0] addr, logic [31:0] net, logic [5:0] len);
    if (len == 6'd0) begin
      return 1'b1;
    end
    if (len > PrefixFull) begin
      return 1'b0;
    end
    return ((addr ^ net) & prefix_mask(len)) == 32'h0;
  endfunction

  // Updates the shadow tables on writes; first hit of the selected table on classify.
  function automatic verdict_t classify_verdict(hdr_t h);
    verdict_t v;
    rule_t    r;
    int       n;
    bit       ports;
    v = '0;
    if (h.op == OpWrite) begin
      if (h.kind == KindTcp) begin
        tcp_tab[h.idx] = h.body;
      end else if (h.kind == KindIp) begin
        ip_tab[h.idx] = h.body;
      end
      return v;
    end
    if (h.kind == KindOther) begin
      return v;
    end
    n = (h.kind == KindTcp) ? int'(tcp_n) : int'(ip_n);
    if (n > RuleSlots) begin
      n = RuleSlots;
    end
    ports = (h.kind != KindIcmp);
    for (int i = 0; i < n; i++) begin
      r = (h.kind == KindTcp) ? tcp_tab[i] : ip_tab[i];
      if ((!ports || ((r.any[0] || r.sport == h.body.sport) &&
                      (r.any[1] || r.dport == h.body.dport))) &&
          addr_in_prefix(h.body.saddr, r.saddr, r.slen) &&
          addr_in_prefix(h.body.daddr, r.daddr, r.dlen)) begin
        v.hit   = 1'b1;
        v.idx   = i[3:0];
        v.alarm = r.alarm;
        v.proto = r.proto;
        return v;
      end
    end
    return v;
  endfunction

  function automatic rule_t mk_rule(logic [31:0] sa, logic [5:0] sl, logic [31:0] da,
                                    logic [5:0] dl, logic [15:0] sp, logic [15:0] dp,
                                    logic [1:0] any, logic [3:0] alarm, logic [3:0] proto);
    rule_t r;
    r.saddr = sa;
    r.slen  = sl;
    r.daddr = da;
    r.dlen  = dl;
    r.sport = sp;
    r.dport = dp;
    r.any   = any;
    r.alarm = alarm;
    r.proto = proto;
    return r;
  endfunction

  function automatic row_t item_row(logic op, logic [1:0] kind, logic [3:0] idx, rule_t b,
                                    bit want_zero);
    row_t w;
    w.set_cnt   = 1'b0;
    w.tcp_cnt   = '0;
    w.ip_cnt    = '0;
    w.h.op      = op;
    w.h.kind    = kind;
    w.h.idx     = idx;
    w.h.body    = b;
    w.want_zero = want_zero;
    return w;
  endfunction

  function automatic row_t cnt_row(logic [4:0] tcp_cnt, logic [4:0] ip_cnt);
    row_t w;
    w = item_row(OpWrite, KindTcp, 4'd0, '0, 1'b0);
    w.set_cnt = 1'b1;
    w.tcp_cnt = tcp_cnt;
    w.ip_cnt  = ip_cnt;
    return w;
  endfunction

  function automatic logic [5:0] rand_len();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      return 6'd0;
    end
    if (sel == 1) begin
      return 6'($urandom_range(33, 63));
    end
    return 6'($urandom_range(1, 32));
  endfunction

  function automatic rule_t rand_rule();
    return mk_rule($urandom, rand_len(), $urandom, rand_len(), 16'($urandom), 16'($urandom),
                   2'($urandom), 4'($urandom), 4'($urandom));
  endfunction

  function automatic logic [4:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      return 5'd0;
    end
    if (sel == 1) begin
      return 5'(RuleSlots);
    end
    return 5'($urandom_range(1, RuleSlots - 1));
  endfunction

  // Mostly packets aimed at an active rule, some flipped, plus noise and writes.
  function automatic hdr_t next_random_hdr();
    hdr_t        h;
    rule_t       src;
    int unsigned sel;
    bit          use_tcp;
    int          n;
    logic [31:0] m;
    sel    = $urandom_range(0, 19);
    h.idx  = 4'($urandom);
    h.body = rand_rule();
    if (sel < 3) begin
      h.op   = OpWrite;
      h.kind = (sel == 0 && $urandom_range(0, 1) == 1) ? 2'($urandom_range(2, 3))
                                                       : 2'($urandom_range(0, 1));
      return h;
    end
    h.op = OpClassify;
    if (sel < 5) begin
      h.kind = 2'($urandom);
      return h;
    end
    use_tcp = ($urandom_range(0, 1) == 1);
    h.kind  = use_tcp ? KindTcp : ($urandom_range(0, 1) == 1 ? KindUdp : KindIcmp);
    n       = use_tcp ? int'(tcp_n) : int'(ip_n);
    if (n == 0) begin
      return h;
    end
    src = use_tcp ? tcp_tab[$urandom_range(0, n - 1)] : ip_tab[$urandom_range(0, n - 1)];
    m = prefix_mask(src.slen);
    h.body.saddr = (src.saddr & m) | (h.body.saddr & ~m);
    m = prefix_mask(src.dlen);
    h.body.daddr = (src.daddr & m) | (h.body.daddr & ~m);
    if (!src.any[0]) begin
      h.body.sport = src.sport;
    end
    if (!src.any[1]) begin
      h.body.dport = src.dport;
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: h.body.saddr[$urandom_range(0, 31)] ^= 1'b1;
        1: h.body.daddr[$urandom_range(0, 31)] ^= 1'b1;
        2: h.body.sport[$urandom_range(0, 15)] ^= 1'b1;
        default: h.body.dport[$urandom_range(0, 15)] ^= 1'b1;
      endcase
    end
    return h;
  endfunction

  task automatic send_word(hdr_t h, bit want_zero);
    verdict_t v;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, h.body.proto, h.body.alarm, h.body.any, h.body.dport, h.body.sport,
                      h.body.dlen, h.body.daddr, h.body.slen, h.body.saddr, h.idx};
    s_axis_tuser  <= {h.kind, h.op};
    do @(posedge clk_i); while (!s_axis_tready);
    v = classify_verdict(h);
    verdict_q.push_back(want_zero ? verdict_t'('0) : v);
    items_sent++;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_counts(logic [4:0] tcp_cnt, logic [4:0] ip_cnt);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTcpCount;
    cfg_data_i <= tcp_cnt;
    @(posedge clk_i);
    cfg_idx_i  <= CfgIpCount;
    cfg_data_i <= ip_cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tcp_n = tcp_cnt;
    ip_n  = ip_cnt;
    @(posedge clk_i);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit   = m_axis_tuser[0];
      got.idx   = m_axis_tdata[3:0];
      got.alarm = m_axis_tdata[7:4];
      got.proto = m_axis_tdata[11:8];
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: unexpected word hit=%0d idx=%0d alarm=%0d proto=%0d",
                   got.hit, got.idx, got.alarm, got.proto);
        end
      end else begin
        want = verdict_q.pop_front();
        if (got.hit !== want.hit || got.idx !== want.idx || got.alarm !== want.alarm ||
            got.proto !== want.proto) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch hit %0d/%0d idx %0d/%0d alarm %0d/%0d proto %0d/%0d",
                     want.hit, got.hit, want.idx, got.idx, want.alarm, got.alarm,
                     want.proto, got.proto);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    hdr_t h;
    int   phase;
    // counts are still zero after reset
    dir_rows.push_back(item_row(OpClassify, KindTcp, 4'd15,
        mk_rule(32'hFFFF_FFFF, 6'd63, 32'h0, 6'd0, 16'hFFFF, 16'h0, 2'd3, 4'd15, 4'd15), 1'b1));
    dir_rows.push_back(item_row(OpClassify, KindUdp, 4'd0,
        mk_rule(32'h0, 6'd0, 32'hFFFF_FFFF, 6'd63, 16'h0, 16'hFFFF, 2'd0, 4'd0, 4'd0), 1'b1));
    dir_rows.push_back(item_row(OpClassify, KindOther, 4'd7,
        mk_rule(32'h0A00_0001, 6'd8, 32'h0, 6'd0, 16'd80, 16'd0, 2'd0, 4'd1, 4'd2), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindTcp, 4'd0,
        mk_rule(32'h0A00_0000, 6'd8, 32'h0, 6'd0, 16'd80, 16'd0, 2'd2, 4'd1, 4'd2), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindTcp, 4'd1,
        mk_rule(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 16'hFFFF, 2'd0,
                4'd15, 4'd15), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindTcp, 4'd2,
        mk_rule(32'h0, 6'd33, 32'h0, 6'd0, 16'd0, 16'd0, 2'd3, 4'd3, 4'd3), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindTcp, 4'd3,
        mk_rule(32'h1234_5678, 6'd0, 32'h8765_4321, 6'd0, 16'd1, 16'd2, 2'd3, 4'd4, 4'd5),
        1'b1));
    dir_rows.push_back(item_row(OpWrite, KindIp, 4'd0,
        mk_rule(32'hC0A8_0000, 6'd16, 32'h0, 6'd0, 16'd53, 16'd0, 2'd0, 4'd6, 4'd7), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindIp, 4'd1,
        mk_rule(32'h0, 6'd0, 32'h0, 6'd63, 16'd0, 16'd0, 2'd3, 4'd8, 4'd8), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindIp, 4'd2,
        mk_rule(32'h0, 6'd32, 32'h1234_5678, 6'd31, 16'd0, 16'd1000, 2'd1, 4'd9, 4'd10),
        1'b1));
    dir_rows.push_back(item_row(OpWrite, KindIp, 4'd3,
        mk_rule(32'hFFFF_FFFF, 6'd0, 32'h0, 6'd0, 16'hFFFF, 16'h0, 2'd3, 4'd11, 4'd12), 1'b1));
    // writes to the unused kinds leave both tables alone
    dir_rows.push_back(item_row(OpWrite, KindIcmp, 4'd5,
        mk_rule(32'h0, 6'd0, 32'h0, 6'd0, 16'd0, 16'd0, 2'd3, 4'd13, 4'd13), 1'b1));
    dir_rows.push_back(item_row(OpWrite, KindOther, 4'd0,
        mk_rule(32'h0, 6'd0, 32'h0, 6'd0, 16'd0, 16'd0, 2'd3, 4'd14, 4'd14), 1'b1));
    dir_rows.push_back(cnt_row(5'd4, 5'd4));
    dir_rows.push_back(item_row(OpClassify, KindTcp, 4'd0,
        mk_rule(32'h0A01_0203, 6'd0, 32'h0, 6'd0, 16'd80, 16'd9, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindTcp, 4'd0,
        mk_rule(32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 6'd0, 16'hFFFF, 16'hFFFF, 2'd0,
                4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindTcp, 4'd0,
        mk_rule(32'h0, 6'd0, 32'h0, 6'd0, 16'd0, 16'd0, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindUdp, 4'd0,
        mk_rule(32'hC0A8_0505, 6'd0, 32'h0, 6'd0, 16'd53, 16'd1, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindUdp, 4'd0,
        mk_rule(32'h0, 6'd0, 32'h1234_5679, 6'd0, 16'd7, 16'd1000, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindIcmp, 4'd0,
        mk_rule(32'hC0A8_0101, 6'd0, 32'h0, 6'd0, 16'd1234, 16'd4321, 2'd0, 4'd0, 4'd0),
        1'b0));
    dir_rows.push_back(item_row(OpClassify, KindIcmp, 4'd0,
        mk_rule(32'h0102_0304, 6'd0, 32'h0, 6'd0, 16'd0, 16'd0, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindOther, 4'd0,
        mk_rule(32'h0A00_0001, 6'd0, 32'h0, 6'd0, 16'd80, 16'd0, 2'd0, 4'd0, 4'd0), 1'b1));
    dir_rows.push_back(cnt_row(5'd1, 5'd0));
    dir_rows.push_back(item_row(OpClassify, KindTcp, 4'd0,
        mk_rule(32'h0101_0101, 6'd0, 32'h0, 6'd0, 16'd80, 16'd0, 2'd0, 4'd0, 4'd0), 1'b0));
    dir_rows.push_back(item_row(OpClassify, KindUdp, 4'd0,
        mk_rule(32'hC0A8_0000, 6'd0, 32'h0, 6'd0, 16'd53, 16'd0, 2'd0, 4'd0, 4'd0), 1'b1));

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].set_cnt) begin
        set_counts(dir_rows[k].tcp_cnt, dir_rows[k].ip_cnt);
      end else begin
        send_word(dir_rows[k].h, dir_rows[k].want_zero);
      end
    end

    // fill both tables so any count can be scanned safely
    for (int t = 0; t < 2; t++) begin
      for (int e = 0; e < RuleSlots; e++) begin
        h.op   = OpWrite;
        h.kind = (t == 0) ? KindTcp : KindIp;
        h.idx  = e[3:0];
        h.body = rand_rule();
        send_word(h, 1'b0);
      end
    end

    phase = 0;
    while (items_sent < 430) begin
      case (phase)
        0: set_counts(5'(RuleSlots), 5'd0);
        1: set_counts(5'd0, 5'(RuleSlots));
        2: set_counts(5'(RuleSlots), 5'(RuleSlots));
        default: set_counts(pick_count(), pick_count());
      endcase
      repeat ($urandom_range(20, 50)) begin
        if (items_sent >= 390) begin
          calm = 1'b1;
        end
        send_word(next_random_hdr(), 1'b0);
      end
      phase++;
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
